@@ rtl/pgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared constants, codes and types of the proportional glyph blit address
// generator.
// ----------------------------------------------------------------------------
package pgb_pkg;

    // glyph table
    localparam int GLYPH_COUNT   = 10;
    localparam int MAX_FONT_ROWS = 64;
    localparam int GLYPH_AW      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int SCAN_GW       = $clog2(GLYPH_COUNT + 1);
    localparam int ROW_W         = $clog2(MAX_FONT_ROWS + 1);

    // field widths
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 16;
    localparam int HEIGHT_W = 7;
    localparam int SRC_W    = 16;
    localparam int DST_W    = 17;
    localparam int ENTRY_W  = 2 * COORD_W;

    // opcodes
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DELIM  = 2'd0;
    localparam logic [1:0] CFG_STRIP  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_STRIDE = 2'd3;

    // configuration reset values
    localparam logic [COLOR_W-1:0]  RST_DELIM  = 16'h7C1F;
    localparam logic [COORD_W-1:0]  RST_STRIP  = 10'd300;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 7'd32;
    localparam logic [COORD_W-1:0]  RST_STRIDE = 10'd240;

    // characters
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] width;
    } t_glyph_entry;

endpackage

@@ rtl/pgb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/proportional_glyph_blit_address_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_glyph_blit_address_gen
// Learns a glyph table (column, width) from a font strip's top row and turns
// digit text into one row-copy descriptor per font row.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  input   | in        | i_valid / o_ready          | opcode, pixel, first_pixel,
//          |           |                            | start_x, start_y, character
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  result  | out       | o_valid / i_ready          | source_offset, dest_offset,
//          |           |                            | copy_count, last
//
//  Strip pixel: accept, table read, write back to the glyph RAM; a delimiter
//  pixel or a dropped pixel skips the write back. Begin, newline and ignored
//  characters: accept, then execute. Digit: accept, execute, entry load,
//  then min(font_height, 64) descriptors; the output register emits one
//  descriptor per cycle from add-only accumulators while the output is not
//  stalled. Reset clears the scan state, cursor and glyph valid bits; an
//  entry without its valid bit reads as zero. An output stall holds the row
//  sequencer; a new item is taken while the final descriptor still waits.
// ----------------------------------------------------------------------------
module proportional_glyph_blit_address_gen
    import pgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic [COLOR_W-1:0]   i_pixel,
    input  logic                 i_first_pixel,
    input  logic [COORD_W-1:0]   i_start_x,
    input  logic [COORD_W-1:0]   i_start_y,
    input  logic [7:0]           i_character,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    // result items
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SRC_W-1:0]     o_source_offset,
    output logic [DST_W-1:0]     o_dest_offset,
    output logic [COORD_W-1:0]   o_copy_count,
    output logic                 o_last
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_PIX_WB  = 3'd2;
    localparam logic [2:0] ST_DRAW_LD = 3'd3;
    localparam logic [2:0] ST_DRAW    = 3'd4;

    // configuration
    logic [COLOR_W-1:0]  r_delim;
    logic [COORD_W-1:0]  r_strip_w;
    logic [HEIGHT_W-1:0] r_font_h;
    logic [COORD_W-1:0]  r_stride;

    // captured item
    logic [1:0]          r_op;
    logic [COLOR_W-1:0]  r_pix;
    logic                r_first;
    logic [COORD_W-1:0]  r_sx;
    logic [COORD_W-1:0]  r_sy;
    logic [7:0]          r_ch;

    // control and scan state
    logic [2:0]           r_state,      n_state;
    logic [COORD_W-1:0]   r_scan_col,   n_scan_col;
    logic [SCAN_GW-1:0]   r_scan_glyph, n_scan_glyph;
    logic                 r_scan_gap,   n_scan_gap;
    logic [GLYPH_COUNT-1:0] r_gvalid,   n_gvalid;
    logic [COORD_W-1:0]   r_cur_x,      n_cur_x;
    logic [COORD_W-1:0]   r_cur_y,      n_cur_y;
    logic [COORD_W-1:0]   r_line_x,     n_line_x;

    // read-modify-write context
    logic [GLYPH_AW-1:0]  r_addr,       n_addr;
    logic                 r_hit,        n_hit;
    logic                 r_new_glyph,  n_new_glyph;
    logic [COORD_W-1:0]   r_wcol,       n_wcol;

    // row sequencer
    logic [COORD_W-1:0]   r_gwid,       n_gwid;
    logic [SRC_W-1:0]     r_src,        n_src;
    logic [DST_W-1:0]     r_dst,        n_dst;
    logic [ROW_W-1:0]     r_row,        n_row;

    // output register
    logic                 r_o_valid,    n_o_valid;
    logic [SRC_W-1:0]     r_o_src,      n_o_src;
    logic [DST_W-1:0]     r_o_dst,      n_o_dst;
    logic [COORD_W-1:0]   r_o_cnt,      n_o_cnt;
    logic                 r_o_last,     n_o_last;

    // RAM port
    logic                 ram_we;
    logic [GLYPH_AW-1:0]  ram_raddr;
    t_glyph_entry         ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    t_glyph_entry         rd_entry;
    logic [ROW_W-1:0]     rows;
    logic                 out_load;
    logic                 row_last;
    logic [7:0]           digit;
    logic                 is_digit;
    logic [COORD_W-1:0]   eff_col;
    logic [SCAN_GW-1:0]   eff_glyph;
    logic                 eff_gap;
    logic [SCAN_GW-1:0]   next_glyph;
    logic [2*COORD_W-1:0] base_prod;

    pgb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_valid         = r_o_valid;
    assign o_source_offset = r_o_src;
    assign o_dest_offset   = r_o_dst;
    assign o_copy_count    = r_o_cnt;
    assign o_last          = r_o_last;

    // never-written entries read as zero
    assign rd_entry = r_hit ? t_glyph_entry'(ram_rdata) : '0;

    assign rows = (r_font_h > HEIGHT_W'(MAX_FONT_ROWS)) ? ROW_W'(MAX_FONT_ROWS)
                                                         : ROW_W'(r_font_h);
    assign row_last = ((r_row + ROW_W'(1)) == rows);
    assign out_load = (r_state == ST_DRAW) && (!r_o_valid || i_ready);

    assign digit    = r_ch - CHAR_ZERO;
    assign is_digit = (r_ch >= CHAR_ZERO) && (r_ch <= CHAR_NINE)
                      && (digit < 8'(GLYPH_COUNT));

    // a new strip restarts the scan before the pixel is looked at
    assign eff_col    = r_first ? '0 : r_scan_col;
    assign eff_glyph  = r_first ? '0 : r_scan_glyph;
    assign eff_gap    = r_first ? 1'b0 : r_scan_gap;
    assign next_glyph = eff_glyph + SCAN_GW'(eff_gap);

    assign base_prod = r_cur_y * r_stride;

    always_comb begin
        ram_raddr = GLYPH_AW'(digit);
        if (r_op == OP_PIXEL) begin
            ram_raddr = GLYPH_AW'(next_glyph);
        end
        ram_we          = (r_state == ST_PIX_WB);
        ram_wdata.col   = r_new_glyph ? r_wcol : rd_entry.col;
        ram_wdata.width = rd_entry.width + COORD_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_scan_col   = r_scan_col;
        n_scan_glyph = r_scan_glyph;
        n_scan_gap   = r_scan_gap;
        n_gvalid     = r_gvalid;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_line_x     = r_line_x;
        n_addr       = r_addr;
        n_hit        = r_hit;
        n_new_glyph  = r_new_glyph;
        n_wcol       = r_wcol;
        n_gwid       = r_gwid;
        n_src        = r_src;
        n_dst        = r_dst;
        n_row        = r_row;
        n_o_valid    = r_o_valid;
        n_o_src      = r_o_src;
        n_o_dst      = r_o_dst;
        n_o_cnt      = r_o_cnt;
        n_o_last     = r_o_last;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_PIXEL: begin
                        n_scan_col   = eff_col;
                        n_scan_glyph = eff_glyph;
                        n_scan_gap   = eff_gap;
                        if (r_first) begin
                            n_gvalid = '0;
                        end
                        if (eff_col < r_strip_w && eff_glyph < SCAN_GW'(GLYPH_COUNT)) begin
                            n_scan_col = eff_col + COORD_W'(1);
                            if (r_pix == r_delim) begin
                                n_scan_gap = 1'b1;
                            end else begin
                                n_scan_gap   = 1'b0;
                                n_scan_glyph = next_glyph;
                                if (next_glyph < SCAN_GW'(GLYPH_COUNT)) begin
                                    n_addr      = GLYPH_AW'(next_glyph);
                                    n_hit       = r_first ? 1'b0
                                                          : r_gvalid[GLYPH_AW'(next_glyph)];
                                    n_new_glyph = eff_gap;
                                    n_wcol      = eff_col;
                                    n_state     = ST_PIX_WB;
                                end
                            end
                        end
                    end
                    OP_BEGIN: begin
                        n_cur_x  = r_sx;
                        n_cur_y  = r_sy;
                        n_line_x = r_sx;
                    end
                    OP_CHAR: begin
                        if (r_ch == CHAR_NEWLINE) begin
                            n_cur_y = r_cur_y + COORD_W'(r_font_h);
                            n_cur_x = r_line_x;
                        end else if (is_digit) begin
                            n_hit   = r_gvalid[GLYPH_AW'(digit)];
                            n_state = ST_DRAW_LD;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_PIX_WB: begin
                n_gvalid[r_addr] = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_DRAW_LD: begin
                n_gwid = rd_entry.width;
                n_src  = SRC_W'(rd_entry.col);
                n_dst  = DST_W'(base_prod) + DST_W'(r_cur_x);
                n_row  = '0;
                if (rows == '0) begin
                    n_cur_x = r_cur_x + rd_entry.width;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_o_src   = r_src;
                    n_o_dst   = r_dst;
                    n_o_cnt   = r_gwid;
                    n_o_last  = row_last;
                    n_src     = r_src + SRC_W'(r_strip_w);
                    n_dst     = r_dst + DST_W'(r_stride);
                    n_row     = r_row + ROW_W'(1);
                    if (row_last) begin
                        n_cur_x = r_cur_x + r_gwid;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_col   <= '0;
            r_scan_glyph <= '0;
            r_scan_gap   <= 1'b0;
            r_gvalid     <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_line_x     <= '0;
            r_o_valid    <= 1'b0;
            r_delim      <= RST_DELIM;
            r_strip_w    <= RST_STRIP;
            r_font_h     <= RST_HEIGHT;
            r_stride     <= RST_STRIDE;
        end else begin
            r_state      <= n_state;
            r_scan_col   <= n_scan_col;
            r_scan_glyph <= n_scan_glyph;
            r_scan_gap   <= n_scan_gap;
            r_gvalid     <= n_gvalid;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_line_x     <= n_line_x;
            r_o_valid    <= n_o_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DELIM:  r_delim   <= i_cfg_data;
                    CFG_STRIP:  r_strip_w <= i_cfg_data[COORD_W-1:0];
                    CFG_HEIGHT: r_font_h  <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_STRIDE: r_stride  <= i_cfg_data[COORD_W-1:0];
                    default:    r_delim   <= r_delim;
                endcase
            end
        end
    end

    // payload and context: no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= i_opcode;
            r_pix   <= i_pixel;
            r_first <= i_first_pixel;
            r_sx    <= i_start_x;
            r_sy    <= i_start_y;
            r_ch    <= i_character;
        end
        r_addr      <= n_addr;
        r_hit       <= n_hit;
        r_new_glyph <= n_new_glyph;
        r_wcol      <= n_wcol;
        r_gwid      <= n_gwid;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_row       <= n_row;
        r_o_src     <= n_o_src;
        r_o_dst     <= n_o_dst;
        r_o_cnt     <= n_o_cnt;
        r_o_last    <= n_o_last;
    end

    // scan never runs past one slot beyond the table
    a_glyph_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_glyph <= SCAN_GW'(GLYPH_COUNT))
        else $error("scan glyph index beyond table");

    // row counter stays inside the font height while drawing
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (r_row < rows))
        else $error("row counter past font height");

    // the final descriptor of a glyph releases the sequencer
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && row_last) |=> (r_state == ST_IDLE))
        else $error("sequencer busy after final descriptor");

    // a new strip leaves at most the entry it just wrote valid
    a_new_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_op == OP_PIXEL && r_first) |=> ##1
        ($countones(r_gvalid) <= 1))
        else $error("table not cleared on new strip");

endmodule
